/* hdl/assert_macros.svh */
// assertion helpers used by rrts_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RRTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/rrts_pkg.sv */
package rrts_pkg;

    localparam int THREADS_DEF    = 16;
    localparam int SEMAPHORES_DEF = 128;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_LAST = 2'd2;

    typedef enum logic [3:0] {
        CMD_SCHEDULE  = 4'd0,
        CMD_CREATE    = 4'd1,
        CMD_EXIT      = 4'd2,
        CMD_SLEEP     = 4'd3,
        CMD_JOIN      = 4'd4,
        CMD_SEM_ALLOC = 4'd5,
        CMD_SEM_FREE  = 4'd6,
        CMD_SEM_DOWN  = 4'd7,
        CMD_SEM_UP    = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        SS_TERM  = 3'd0,
        SS_READY = 3'd1,
        SS_RUN   = 3'd2,
        SS_SLEEP = 3'd3,
        SS_BLOCK = 3'd4
    } t_slot_st;

    typedef enum logic [4:0] {
        A_NONE, A_LATCH, A_CLR, A_SCHED, A_SLEEP, A_CREATE, A_COUNT,
        A_EXITLAST, A_JREL, A_EXITFIN, A_RESEL, A_JFIND, A_ALLOC,
        A_FREE, A_SEMRD, A_DOWN, A_UP, A_OUT
    } t_act;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_CREATE, S_COUNT, S_EXITDEC, S_JREL, S_EXITFIN,
        S_RESEL, S_JFIND, S_ALLOC, S_FREE, S_DOWN, S_UP, S_OUT
    } t_fsm;

    typedef struct packed {
        t_act act;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic running;
        logic sem_ok;
        logic sem_alloc;
        logic hit;
        logic hit_live;
        logic last;
        logic live_one;
        logic sem_zero;
        logic out_busy;
    } t_dp_sts;

endpackage

/* hdl/rrts_if.sv */
interface rrts_in_if;
    import rrts_pkg::*;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [15:0] sleep_ticks;
    logic [15:0] target_tid;
    logic [6:0]  sem_index;
    logic [31:0] now;
    modport source (output valid, command, sleep_ticks, target_tid, sem_index, now,
                    input ready);
    modport sink (input valid, command, sleep_ticks, target_tid, sem_index, now,
                  output ready);
endinterface

interface rrts_out_if;
    import rrts_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] result_value;
    logic [3:0]  running_slot;
    logic [15:0] running_tid;
    logic        idle;
    modport source (output valid, status, result_value, running_slot, running_tid, idle,
                    input ready);
    modport sink (input valid, status, result_value, running_slot, running_tid, idle,
                  output ready);
endinterface

/* hdl/rrts_ctrl.sv */
`include "assert_macros.svh"

module rrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rrts_pkg::t_dp_sts i_sts,
    output rrts_pkg::t_dp_ctl o_ctl
);
    import rrts_pkg::*;

    t_fsm r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_SCHEDULE:  n_state = S_RESEL;
                    CMD_CREATE:    n_state = S_CREATE;
                    CMD_EXIT:      n_state = i_sts.running ? S_COUNT : S_OUT;
                    CMD_SLEEP:     n_state = i_sts.running ? S_RESEL : S_OUT;
                    CMD_JOIN:      n_state = i_sts.running ? S_JFIND : S_OUT;
                    CMD_SEM_ALLOC: n_state = S_ALLOC;
                    CMD_SEM_FREE:  n_state = i_sts.sem_ok ? S_FREE : S_OUT;
                    CMD_SEM_DOWN:  n_state = (i_sts.running && i_sts.sem_ok &&
                                              i_sts.sem_alloc) ? S_DOWN : S_OUT;
                    CMD_SEM_UP:    n_state = (i_sts.sem_ok && i_sts.sem_alloc) ?
                                             S_UP : S_OUT;
                    default:       n_state = S_OUT;
                endcase
            end
            S_CREATE:  if (i_sts.hit || i_sts.last) n_state = S_OUT;
            S_COUNT:   if (i_sts.last) n_state = S_EXITDEC;
            S_EXITDEC: n_state = i_sts.live_one ? S_OUT : S_JREL;
            S_JREL:    if (i_sts.last) n_state = S_EXITFIN;
            S_EXITFIN: n_state = S_RESEL;
            S_RESEL:   if (i_sts.hit || i_sts.last) n_state = S_OUT;
            S_JFIND: begin
                if (i_sts.hit && i_sts.hit_live) n_state = S_RESEL;
                else if (i_sts.hit || i_sts.last) n_state = S_OUT;
            end
            S_ALLOC:   if (i_sts.hit || i_sts.last) n_state = S_OUT;
            S_FREE:    if (i_sts.last) n_state = S_OUT;
            S_DOWN:    n_state = i_sts.sem_zero ? S_RESEL : S_OUT;
            S_UP:      if (i_sts.hit || i_sts.last) n_state = S_OUT;
            S_OUT:     if (!i_sts.out_busy) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl.act  = A_NONE;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE:    if (i_in_valid) o_ctl.act = A_LATCH;
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_SCHEDULE:  o_ctl.act = A_SCHED;
                    CMD_CREATE:    o_ctl.act = A_CLR;
                    CMD_EXIT:      if (i_sts.running) o_ctl.act = A_CLR;
                    CMD_SLEEP:     if (i_sts.running) o_ctl.act = A_SLEEP;
                    CMD_JOIN:      if (i_sts.running) o_ctl.act = A_CLR;
                    CMD_SEM_ALLOC: o_ctl.act = A_CLR;
                    CMD_SEM_FREE:  if (i_sts.sem_ok) o_ctl.act = A_CLR;
                    CMD_SEM_DOWN:  if (i_sts.running && i_sts.sem_ok && i_sts.sem_alloc)
                                       o_ctl.act = A_SEMRD;
                    CMD_SEM_UP:    if (i_sts.sem_ok && i_sts.sem_alloc) o_ctl.act = A_CLR;
                    default:       o_ctl.act = A_NONE;
                endcase
            end
            S_CREATE:  o_ctl.act = A_CREATE;
            S_COUNT:   o_ctl.act = A_COUNT;
            S_EXITDEC: o_ctl.act = i_sts.live_one ? A_EXITLAST : A_CLR;
            S_JREL:    o_ctl.act = A_JREL;
            S_EXITFIN: o_ctl.act = A_EXITFIN;
            S_RESEL:   o_ctl.act = A_RESEL;
            S_JFIND:   o_ctl.act = A_JFIND;
            S_ALLOC:   o_ctl.act = A_ALLOC;
            S_FREE:    o_ctl.act = A_FREE;
            S_DOWN:    o_ctl.act = A_DOWN;
            S_UP:      o_ctl.act = A_UP;
            S_OUT:     if (!i_sts.out_busy) o_ctl.act = A_OUT;
            default:   o_ctl.act = A_NONE;
        endcase
    end

    `RRTS_ASSERT_NEXT(a_accept_disp, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state == S_DISP, "request not dispatched")
    `RRTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) && i_sts.out_busy, r_state == S_OUT, "result overwritten")
    `RRTS_ASSERT_NEXT(a_resel_stay, i_clk, i_rst_n, (r_state == S_RESEL) && !i_sts.hit && !i_sts.last, r_state == S_RESEL, "scan ended early")

endmodule

/* hdl/rrts_dp.sv */
module rrts_dp #(
    parameter int THREADS    = rrts_pkg::THREADS_DEF,
    parameter int SEMAPHORES = rrts_pkg::SEMAPHORES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrts_pkg::t_dp_ctl i_ctl,
    output rrts_pkg::t_dp_sts o_sts,
    input  logic [3:0]        i_command,
    input  logic [15:0]       i_sleep_ticks,
    input  logic [15:0]       i_target_tid,
    input  logic [6:0]        i_sem_index,
    input  logic [31:0]       i_now,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [15:0]       o_result_value,
    output logic [3:0]        o_running_slot,
    output logic [15:0]       o_running_tid,
    output logic              o_idle
);
    import rrts_pkg::*;

    localparam int SW  = $clog2(THREADS);
    localparam int SMW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam int LW  = $clog2(THREADS + 1);

    // slot table
    t_slot_st    r_st [THREADS];
    logic [15:0] r_tid [THREADS];
    logic [31:0] r_wake [THREADS];
    logic        r_jw_v [THREADS];
    logic [15:0] r_jw_tid [THREADS];
    logic        r_sw_v [THREADS];
    logic [7:0]  r_sw_idx [THREADS];

    // semaphores: allocated flags in flops, free/taken bit in memory
    logic [SEMAPHORES-1:0] r_alloc;
    logic                  r_sem_mem [SEMAPHORES];
    logic                  r_sem_rd;

    logic [SW-1:0]  r_cur, r_idx, r_cnt;
    logic [SMW-1:0] r_sscan;
    logic [LW-1:0]  r_live;
    logic [15:0]    r_next_tid;
    logic           r_idle;

    logic [3:0]  r_cmd;
    logic [15:0] r_ticks, r_target;
    logic [6:0]  r_sidx;
    logic [31:0] r_now;
    logic [1:0]  r_status;
    logic [15:0] r_value;

    logic           running, sem_ok, hit, hit_live, last;
    logic [SMW-1:0] saddr;
    logic [7:0]     sidx8;
    t_slot_st       e_st;
    logic           mem_we, mem_wd;
    logic [SMW-1:0] mem_wa;

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i);
        return (i == SW'(THREADS - 1)) ? '0 : SW'(i + 1'b1);
    endfunction

    always_comb begin
        running  = (r_st[r_cur] == SS_RUN);
        sem_ok   = (32'(r_sidx) < 32'(SEMAPHORES));
        saddr    = SMW'(r_sidx);
        sidx8    = 8'(r_sidx);
        e_st     = r_st[r_idx];
        hit      = 1'b0;
        hit_live = (e_st != SS_TERM);
        last     = (r_cnt == SW'(THREADS - 1));
        case (i_ctl.act)
            A_CREATE: hit = (e_st == SS_TERM);
            A_RESEL:  hit = (e_st == SS_READY) ||
                            ((e_st == SS_SLEEP) && (r_wake[r_idx] <= r_now));
            A_JFIND:  hit = (r_tid[r_idx] == r_target);
            A_UP:     hit = r_sw_v[r_idx] && (r_sw_idx[r_idx] == sidx8);
            A_ALLOC: begin
                hit  = !r_alloc[r_sscan];
                last = (r_sscan == SMW'(SEMAPHORES - 1));
            end
            default:  hit = 1'b0;
        endcase
        o_sts.cmd       = t_cmd'(r_cmd);
        o_sts.running   = running;
        o_sts.sem_ok    = sem_ok;
        o_sts.sem_alloc = r_alloc[saddr];
        o_sts.hit       = hit;
        o_sts.hit_live  = hit_live;
        o_sts.last      = last;
        o_sts.live_one  = (r_live == LW'(1));
        o_sts.sem_zero  = !r_sem_rd;
        o_sts.out_busy  = o_valid && !i_ready;
    end

    // semaphore value memory write port
    always_comb begin
        mem_we = 1'b0;
        mem_wd = 1'b1;
        mem_wa = saddr;
        case (i_ctl.act)
            A_ALLOC: begin
                mem_we = hit;
                mem_wa = r_sscan;
            end
            A_DOWN: begin
                mem_we = r_sem_rd;
                mem_wd = 1'b0;
            end
            A_UP:    mem_we = last && !hit;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_sem_mem[mem_wa] <= mem_wd;
        if (i_ctl.act == A_SEMRD) r_sem_rd <= r_sem_mem[saddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < THREADS; i++) begin
                r_st[i]   <= (i == 0) ? SS_RUN : SS_TERM;
                r_tid[i]  <= '0;
                r_jw_v[i] <= 1'b0;
                r_sw_v[i] <= 1'b0;
            end
            r_alloc    <= '0;
            r_cur      <= '0;
            r_next_tid <= 16'd1;
            r_idle     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && i_ready && (i_ctl.act != A_OUT)) o_valid <= 1'b0;
            case (i_ctl.act)
                A_LATCH: begin
                    r_cmd    <= i_command;
                    r_ticks  <= i_sleep_ticks;
                    r_target <= i_target_tid;
                    r_sidx   <= i_sem_index;
                    r_now    <= i_now;
                    r_status <= STATUS_OK;
                    r_value  <= '0;
                end
                A_CLR: begin
                    r_idx   <= '0;
                    r_cnt   <= '0;
                    r_sscan <= '0;
                    r_live  <= '0;
                end
                A_SCHED: begin
                    if (running) r_st[r_cur] <= SS_READY;
                    r_idx <= nxt(r_cur);
                    r_cnt <= '0;
                end
                A_SLEEP: begin
                    r_wake[r_cur] <= r_now + 32'(r_ticks);
                    r_st[r_cur]   <= SS_SLEEP;
                    r_idx         <= nxt(r_cur);
                    r_cnt         <= '0;
                end
                A_CREATE: begin
                    if (hit) begin
                        r_st[r_idx]   <= SS_READY;
                        r_tid[r_idx]  <= r_next_tid;
                        r_jw_v[r_idx] <= 1'b0;
                        r_sw_v[r_idx] <= 1'b0;
                        r_value       <= r_next_tid;
                        r_next_tid    <= r_next_tid + 16'd1;
                    end else if (last) begin
                        r_status <= STATUS_FAIL;
                    end
                    r_idx <= nxt(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
                A_COUNT: begin
                    if (e_st != SS_TERM) r_live <= r_live + 1'b1;
                    r_idx <= nxt(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
                A_EXITLAST: begin
                    r_st[r_cur] <= SS_TERM;
                    r_idle      <= 1'b1;
                    r_status    <= STATUS_LAST;
                end
                A_JREL: begin
                    if (r_jw_v[r_idx] && (r_jw_tid[r_idx] == r_tid[r_cur])) begin
                        r_jw_v[r_idx] <= 1'b0;
                        r_st[r_idx]   <= SS_READY;
                    end
                    r_idx <= nxt(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
                A_EXITFIN: begin
                    r_st[r_cur] <= SS_TERM;
                    r_idx       <= nxt(r_cur);
                    r_cnt       <= '0;
                end
                A_RESEL: begin
                    if (hit) begin
                        r_cur       <= r_idx;
                        r_st[r_idx] <= SS_RUN;
                        r_idle      <= 1'b0;
                    end else if (last) begin
                        r_idle <= 1'b1;
                    end
                    r_idx <= nxt(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
                A_JFIND: begin
                    if (hit && hit_live) begin
                        r_jw_v[r_cur]   <= 1'b1;
                        r_jw_tid[r_cur] <= r_target;
                        r_st[r_cur]     <= SS_BLOCK;
                        r_idx           <= nxt(r_cur);
                        r_cnt           <= '0;
                    end else begin
                        r_idx <= nxt(r_idx);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                A_ALLOC: begin
                    if (hit) begin
                        r_alloc[r_sscan] <= 1'b1;
                        r_value          <= 16'(r_sscan);
                    end else if (last) begin
                        r_status <= STATUS_FAIL;
                    end
                    r_sscan <= r_sscan + 1'b1;
                end
                A_FREE: begin
                    if (r_sw_v[r_idx] && (r_sw_idx[r_idx] == sidx8)) begin
                        r_sw_v[r_idx] <= 1'b0;
                        r_st[r_idx]   <= SS_READY;
                    end
                    if (last) r_alloc[saddr] <= 1'b0;
                    r_idx <= nxt(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
                A_DOWN: begin
                    if (!r_sem_rd) begin
                        r_sw_v[r_cur]   <= 1'b1;
                        r_sw_idx[r_cur] <= sidx8;
                        r_st[r_cur]     <= SS_BLOCK;
                        r_idx           <= nxt(r_cur);
                        r_cnt           <= '0;
                    end
                end
                A_UP: begin
                    if (hit) begin
                        r_sw_v[r_idx] <= 1'b0;
                        r_st[r_idx]   <= SS_READY;
                    end
                    r_idx <= nxt(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
                A_OUT: begin
                    o_valid        <= 1'b1;
                    o_status       <= r_status;
                    o_result_value <= r_value;
                    o_running_slot <= r_idle ? 4'd0 : 4'(r_cur);
                    o_running_tid  <= r_idle ? 16'd0 : r_tid[r_cur];
                    o_idle         <= r_idle;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/round_robin_thread_scheduler_core.sv */
// scanning requests take longer than those that do no scan, and the sequencer also
// waits in its output state while an earlier result is not yet taken by the port
// throughput: one request at a time; the slot scan steps one slot per cycle
// reset: synchronous active-low; slot 0 running with tid 0, next tid 1, no semaphore
// allocated; no clearing pass, the block accepts a request in the first cycle after reset
module round_robin_thread_scheduler_core #(
    parameter int THREADS    = rrts_pkg::THREADS_DEF,
    parameter int SEMAPHORES = rrts_pkg::SEMAPHORES_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    rrts_in_if.sink       i_in,
    rrts_out_if.source    o_out
);
    import rrts_pkg::*;

    // command and status bundles between the sequencer and the datapath
    t_dp_ctl ctl;
    t_dp_sts sts;

    // sequencer: latch a request, dispatch by command, run the slot or
    // semaphore scan, then park the result in the output register
    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // datapath: slot table, semaphore store, scan counters, result register
    rrts_dp #(
        .THREADS    (THREADS),
        .SEMAPHORES (SEMAPHORES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_command      (i_in.command),
        .i_sleep_ticks  (i_in.sleep_ticks),
        .i_target_tid   (i_in.target_tid),
        .i_sem_index    (i_in.sem_index),
        .i_now          (i_in.now),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_status       (o_out.status),
        .o_result_value (o_out.result_value),
        .o_running_slot (o_out.running_slot),
        .o_running_tid  (o_out.running_tid),
        .o_idle         (o_out.idle)
    );

endmodule
